### rtl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned TAG_W  = 16;
  localparam int unsigned PRIO_W = 4;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned OCC_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [TAG_W-1:0]  entry_tag;
    logic [PRIO_W-1:0] entry_priority;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [TAG_W-1:0]  out_tag;
    logic [PRIO_W-1:0] out_priority;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // shared control broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ins;
  } cell_ctl_t;

endpackage

### rtl/spq_cell.sv
module spq_cell (
  input  logic              clk_i,
  input  spq_pkg::cell_ctl_t ctl_i,
  input  logic              occ_i,
  input  spq_pkg::entry_t   prev_entry_i,
  input  logic              prev_disp_i,
  input  spq_pkg::entry_t   next_entry_i,
  output spq_pkg::entry_t   entry_o,
  output logic              disp_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // new entry lands at or before this slot
  assign disp_o = !occ_i || (entry_q.prio < ctl_i.ins.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.enq) begin
      if (disp_o) begin
        entry_d = prev_disp_i ? prev_entry_i : ctl_i.ins;
      end
    end else if (ctl_i.deq) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### rtl/stable_priority_queue_core.sv
// channel | direction | handshake                | payload
// request | in        | req_valid_i / req_ready_o | req_i (kind, tag, priority)
// result  | out       | rsp_valid_o / rsp_ready_i | rsp_o (status, tag, priority, occupancy)
// config  | in        | cfg_we_i                  | cfg_wdata_i (capacity limit)
//
// each request is handled by the row of cells shifting in parallel, so
// insertion and removal update every slot together and the result is registered
// one request per cycle is accepted as long as the result register is free or drained
// a stalled result holds the request side only while it is not taken
// reset clears the fill count, the result valid and sets the capacity to 64;
// cell contents are not cleared, slots at or above the fill count never reach a result
module stable_priority_queue_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  spq_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output spq_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [spq_pkg::CAP_W-1:0] cfg_wdata_i
);
  import spq_pkg::*;

  // fill count must hold DEPTH itself
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // width wide enough for both count and capacity register
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  logic [CW-1:0]    count_q, count_d;
  logic [CAP_W-1:0] cap_q;
  logic             rsp_valid_q;
  rsp_t             rsp_q, rsp_d;

  logic [LW-1:0] cap_ext, eff_lim;
  logic          full, empty, req_fire;
  cell_ctl_t     ctl;

  entry_t        cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_disp;
  logic [DEPTH-1:0] cell_occ;

  // result register decouples the two sides
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign req_fire    = req_valid_i && req_ready_o;

  // zero or over-depth capacity falls back to full depth
  assign cap_ext = LW'(cap_q);
  assign eff_lim = ((cap_q == '0) || (cap_ext > LW'(DEPTH))) ? LW'(DEPTH) : cap_ext;
  assign full    = LW'(count_q) >= eff_lim;
  assign empty   = (count_q == '0);

  assign ctl.enq = req_fire && (req_i.kind == KIND_ENQ) && !full;
  assign ctl.deq = req_fire && (req_i.kind == KIND_DEQ) && !empty;
  assign ctl.ins.tag  = req_i.entry_tag;
  assign ctl.ins.prio = req_i.entry_priority;

  // row of cells, slot 0 is the head
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(gi);
    entry_t prev_entry, next_entry;
    logic   prev_disp;

    assign cell_occ[gi] = count_q > IDX;

    if (gi == 0) begin : g_head
      assign prev_entry = ctl.ins;
      assign prev_disp  = 1'b0;
    end else begin : g_mid
      assign prev_entry = cell_entry[gi-1];
      assign prev_disp  = cell_disp[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_tail
      assign next_entry = cell_entry[gi];
    end else begin : g_body
      assign next_entry = cell_entry[gi+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .occ_i        (cell_occ[gi]),
      .prev_entry_i (prev_entry),
      .prev_disp_i  (prev_disp),
      .next_entry_i (next_entry),
      .entry_o      (cell_entry[gi]),
      .disp_o       (cell_disp[gi])
    );
  end

  // next fill count and result
  always_comb begin
    count_d = count_q;
    if (ctl.enq) begin
      count_d = count_q + CW'(1);
    end else if (ctl.deq) begin
      count_d = count_q - CW'(1);
    end

    rsp_d.status       = ST_DONE;
    rsp_d.out_tag      = '0;
    rsp_d.out_priority = '0;
    if (req_i.kind == KIND_ENQ) begin
      if (full) begin
        rsp_d.status = ST_FULL;
      end
    end else if (empty) begin
      rsp_d.status = ST_EMPTY;
    end else begin
      // head leaves on dequeue
      rsp_d.out_tag      = cell_entry[0].tag;
      rsp_d.out_priority = cell_entry[0].prio;
    end
    rsp_d.occupancy = OCC_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // fill count never passes the row length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(count_q) <= LW'(DEPTH))
    else $error("fill count beyond depth");

  // a successful dequeue drops the count by exactly one
  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && (req_i.kind == KIND_DEQ) && (count_q != '0))
      |=> (count_q == $past(count_q) - CW'(1)))
    else $error("dequeue did not shrink the queue by one");

  // a full enqueue leaves the count unchanged
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && (req_i.kind == KIND_ENQ) && full) |=> $stable(count_q))
    else $error("rejected enqueue changed the fill count");

  // an empty status always reports zero occupancy and a zero out tag
  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.status == ST_EMPTY))
      |-> ((rsp_q.occupancy == '0) && (rsp_q.out_tag == '0)))
    else $error("empty status with nonzero fields");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 64;

  logic  clk_i;
  logic  rst_ni;
  logic  req_valid_i;
  logic  req_ready_o;
  req_t  req_i;
  logic  rsp_valid_o;
  logic  rsp_ready_i;
  rsp_t  rsp_o;
  logic  cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  // idling mix, percent of cycles in which each side holds back
  int unsigned req_idle_pct;
  int unsigned rsp_stall_pct;

  // shadow copy of the queue contents and the capacity register
  entry_t           shadow_entries[$];
  logic [CAP_W-1:0] shadow_cap;

  // responses owed by the block, oldest first
  rsp_t owed_responses[$];
  rsp_t oldest_owed;

  int unsigned err_count;
  int unsigned req_count;
  int unsigned full_count;
  int unsigned empty_count;

  stable_priority_queue_core #(
    .DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  // applies one request to the shadow queue and returns the response it owes
  function automatic rsp_t serve_request(input req_t r);
    rsp_t        res;
    entry_t      e;
    int unsigned lim;
    int unsigned pos;
    res = '0;
    res.status = ST_DONE;
    // zero or anything past the depth means the full depth
    lim = (shadow_cap == 0 || 32'(shadow_cap) > QUEUE_DEPTH) ? QUEUE_DEPTH : 32'(shadow_cap);
    if (r.kind == KIND_ENQ) begin
      if (shadow_entries.size() >= lim) begin
        res.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of greater or equal priority
        pos = 0;
        while (pos < shadow_entries.size() && shadow_entries[pos].prio >= r.entry_priority)
          pos++;
        e.tag  = r.entry_tag;
        e.prio = r.entry_priority;
        shadow_entries.insert(pos, e);
      end
    end else if (shadow_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      e = shadow_entries.pop_front();
      res.out_tag      = e.tag;
      res.out_priority = e.prio;
    end
    res.occupancy = OCC_W'(shadow_entries.size());
    return res;
  endfunction

  function automatic req_t random_request(input int unsigned enq_pct,
                                          input int unsigned prio_hi);
    req_t r;
    r.kind           = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
    r.entry_tag      = 16'($urandom);
    r.entry_priority = 4'($urandom_range(prio_hi, 0));
    return r;
  endfunction

  // result side: random stall per cycle
  always @(posedge clk_i) begin
    rsp_ready_i <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // monitor: check the response leaving, then log the request entering;
  // a response never belongs to a request taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (owed_responses.size() == 0) begin
          $error("response with no request outstanding: %h", rsp_o);
          err_count++;
        end else begin
          oldest_owed = owed_responses.pop_front();
          if (rsp_o.status !== oldest_owed.status) begin
            $error("status: expected %0d, got %0d", oldest_owed.status, rsp_o.status);
            err_count++;
          end
          if (rsp_o.out_tag !== oldest_owed.out_tag) begin
            $error("out_tag: expected %h, got %h", oldest_owed.out_tag, rsp_o.out_tag);
            err_count++;
          end
          if (rsp_o.out_priority !== oldest_owed.out_priority) begin
            $error("out_priority: expected %0d, got %0d",
                   oldest_owed.out_priority, rsp_o.out_priority);
            err_count++;
          end
          if (rsp_o.occupancy !== oldest_owed.occupancy) begin
            $error("occupancy: expected %0d, got %0d",
                   oldest_owed.occupancy, rsp_o.occupancy);
            err_count++;
          end
          if (oldest_owed.status == ST_FULL) full_count++;
          if (oldest_owed.status == ST_EMPTY) empty_count++;
        end
      end
      if (req_valid_i && req_ready_o) begin
        owed_responses.push_back(serve_request(req_i));
        req_count++;
      end
    end
  end

  // sends one request; valid stays high into the next call unless a gap is drawn
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid_i <= 1'b0;
      req_i       <= req_t'($bits(req_t)'($urandom));
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  // drop valid and wait until every owed response is back, plus a short pause
  task automatic settle_queue();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_responses.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_cap  = value;
  endtask

  // field extremes, equal priorities leaving in arrival order, empty dequeue
  task automatic test_directed_order();
    send_request(req_t'{KIND_DEQ, 16'hFFFF, 4'hF});
    send_request(req_t'{KIND_ENQ, 16'h0000, 4'h0});
    send_request(req_t'{KIND_ENQ, 16'hFFFF, 4'hF});
    send_request(req_t'{KIND_ENQ, 16'h1111, 4'h5});
    send_request(req_t'{KIND_ENQ, 16'h2222, 4'h5});
    send_request(req_t'{KIND_ENQ, 16'h3333, 4'h5});
    send_request(req_t'{KIND_ENQ, 16'hAAAA, 4'h0});
    send_request(req_t'{KIND_ENQ, 16'h5555, 4'hF});
    send_request(req_t'{KIND_ENQ, 16'h4444, 4'h7});
    // drain: tag and priority on a dequeue must be ignored
    repeat (9) send_request(req_t'{KIND_DEQ, 16'($urandom), 4'($urandom)});
    send_request(req_t'{KIND_DEQ, 16'h0000, 4'h0});
    settle_queue();
  endtask

  // capacity extremes: zero and above depth fall back to the depth,
  // a limit of one, and a limit lowered under the current fill
  task automatic test_capacity_settings();
    write_capacity(7'd0);
    repeat (QUEUE_DEPTH + 1) send_request(random_request(100, 15));
    settle_queue();
    write_capacity(7'd127);
    send_request(random_request(100, 15));
    repeat (QUEUE_DEPTH + 1) send_request(random_request(0, 15));
    settle_queue();
    write_capacity(7'd1);
    send_request(random_request(100, 15));
    send_request(random_request(100, 15));
    send_request(random_request(0, 15));
    settle_queue();
    write_capacity(7'd64);
    repeat (4) send_request(random_request(100, 3));
    settle_queue();
    write_capacity(7'd2);
    send_request(random_request(100, 3));
    repeat (5) send_request(random_request(0, 3));
    settle_queue();
  endtask

  // random traffic under one idling mix, two capacity settings
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned enq_pct;
    int unsigned prio_hi;
    logic [CAP_W-1:0] cap;
    req_idle_pct  = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (2) begin
      case ($urandom_range(5))
        0: cap = 7'd0;
        1: cap = 7'd1;
        2: cap = 7'($urandom_range(8, 2));
        3: cap = 7'd64;
        4: cap = 7'($urandom_range(127, 65));
        default: cap = 7'($urandom_range(63, 9));
      endcase
      write_capacity(cap);
      enq_pct = $urandom_range(75, 35);
      // narrow priority range gives long runs of equal priorities
      prio_hi = $urandom_range(1) ? 15 : 2;
      repeat (52) send_request(random_request(enq_pct, prio_hi));
      settle_queue();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    req_valid_i   <= 1'b0;
    req_i         <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    shadow_cap    = CAP_RESET;
    err_count     = 0;
    req_count     = 0;
    full_count    = 0;
    empty_count   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_order();
    req_idle_pct  = 32;
    rsp_stall_pct = 32;
    test_capacity_settings();
    test_random_traffic(0, 0);
    test_random_traffic(53, 0);
    test_random_traffic(0, 53);
    test_random_traffic(32, 32);

    settle_queue();
    $display("ran %0d requests (%0d full, %0d empty) across capacity 0, 1, 64, 127",
             req_count, full_count, empty_count);
    $display("and random limits, under four sender and receiver idling mixes");
    if (err_count == 0 && owed_responses.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
